>>> rtl/color_overlay_blend_top_macros.svh
// Assertion macros for the color overlay blend block.
// Used by color_overlay_blend_top.sv; expects clk and rst_n in scope.
`ifndef COLOR_OVERLAY_BLEND_TOP_MACROS_SVH
`define COLOR_OVERLAY_BLEND_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define COB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define COB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cob_pkg.sv
// Shared types, constants and tables for the color overlay blend block.
// No dependencies; imported by the interfaces and the top level.
`default_nettype none

package cob_pkg;

    // Fixed-point format: unsigned Q1.FRAC_BITS
    localparam int FRAC_BITS = 16;
    localparam int FX_W      = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * FX_W;

    typedef logic [FX_W-1:0]   fx_t;
    typedef logic [PROD_W-1:0] prod_t;

    localparam fx_t FX_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam fx_t FX_HALF = FX_ONE >> 1;

    // Field widths
    localparam int PIX_W      = 16;
    localparam int FILL_W     = 8;
    localparam int OPAC_W     = 17;
    localparam int SEL_W      = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;

    typedef logic [PIX_W-1:0] pix_t;

    // Channel scales
    localparam int   DEEP_LOG2  = 15;
    localparam pix_t DEEP_SCALE = pix_t'(1) << DEEP_LOG2;
    localparam pix_t BYTE_SCALE = pix_t'(255);

    // Opacity register format: Q1.16
    localparam int                OPAC_FRAC = 16;
    localparam logic [OPAC_W-1:0] OPAC_ONE  = {1'b1, {OPAC_FRAC{1'b0}}};

    // Blend mode codes
    localparam logic [SEL_W-1:0] BLEND_NORMAL   = 3'd0;
    localparam logic [SEL_W-1:0] BLEND_MULTIPLY = 3'd1;
    localparam logic [SEL_W-1:0] BLEND_ADD      = 3'd2;
    localparam logic [SEL_W-1:0] BLEND_SCREEN   = 3'd3;
    localparam logic [SEL_W-1:0] BLEND_DIFF     = 3'd4;
    localparam logic [SEL_W-1:0] BLEND_OVERLAY  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_RED   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_GREEN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_BLUE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY    = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_SEL  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEEP_DEPTH = 8'd5;

    // 8-bit code to Q1.F, round half up: (v * ONE + 127) / 255
    typedef fx_t fx_lut_t [256];

    function automatic fx_lut_t build_byte_lut();
        fx_lut_t lut;
        longint  num;
        for (int i = 0; i < 256; i++) begin
            num    = (longint'(i) << FRAC_BITS) + 64'd127;
            lut[i] = fx_t'(num / 255);
        end
        return lut;
    endfunction

    localparam fx_lut_t FX_BYTE_LUT = build_byte_lut();

endpackage

`default_nettype wire

>>> rtl/cob_pixel_if.sv
// Source pixel channel: valid/ready request with alpha and RGB payload.
// Depends on cob_pkg for the field width.
`default_nettype none

interface cob_pixel_if
    import cob_pkg::*;
();
    logic valid;
    logic ready;
    pix_t src_alpha;
    pix_t src_red;
    pix_t src_green;
    pix_t src_blue;

    modport source (output valid, src_alpha, src_red, src_green, src_blue, input ready);
    modport sink   (input valid, src_alpha, src_red, src_green, src_blue, output ready);
endinterface

`default_nettype wire

>>> rtl/cob_result_if.sv
// Result pixel channel: valid/ready request with alpha and RGB payload.
// Depends on cob_pkg for the field width.
`default_nettype none

interface cob_result_if
    import cob_pkg::*;
();
    logic valid;
    logic ready;
    pix_t out_alpha;
    pix_t out_red;
    pix_t out_green;
    pix_t out_blue;

    modport source (output valid, out_alpha, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_alpha, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

>>> rtl/cob_cfg_if.sv
// Configuration write channel: valid/ready request with register index and data.
// Depends on cob_pkg for the index and data widths.
`default_nettype none

interface cob_cfg_if
    import cob_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/color_overlay_blend_top.sv
// Top level of the color overlay blend block: six-stage pixel pipeline.
// Depends on cob_pkg, the three channel interfaces and the assertion macros.
`default_nettype none

`include "color_overlay_blend_top_macros.svh"

// Solid-color overlay: each RGB channel of a pixel is normalized to Q1.16,
// blended with the programmed fill color (normal, multiply, add, screen,
// difference, overlay), mixed with the source by the fill opacity, and scaled
// back to the 8-bit or deep range. Alpha is passed through. The block takes one
// pixel per clock while the result channel accepts; the six register stages are
// normalize, blend product, blend select, opacity products, mix and clamp, and
// rescale. Every stage carries its own valid bit and fills when empty or when
// the stage after it moves, so a stalled result does not block new pixels until
// all six stages hold one. Configuration writes are always ready and take effect
// at once; they should be made only while no pixel is in flight.
module color_overlay_blend_top
    import cob_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cob_cfg_if.sink     cfg,
    cob_pixel_if.sink   pixel,
    cob_result_if.source result
);

    localparam int NSTG  = 6;
    localparam int NCH   = 3;
    localparam int TW    = PROD_W - FRAC_BITS;
    localparam int DW    = PIX_W + FRAC_BITS + 1;
    localparam int OPA_W = OPAC_W + FRAC_BITS + 1;
    localparam int MW    = PROD_W + 1 - FRAC_BITS;
    localparam int OW    = FX_W + DEEP_LOG2 + 1;

    // Configuration registers
    logic [FILL_W-1:0] fill_reg [NCH];
    logic [OPAC_W-1:0] opac_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic              deep_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                fill_reg[i] <= '1;
            end
            opac_reg <= OPAC_ONE;
            sel_reg  <= BLEND_NORMAL;
            deep_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FILL_RED:   fill_reg[0] <= cfg.data[FILL_W-1:0];
                CFG_FILL_GREEN: fill_reg[1] <= cfg.data[FILL_W-1:0];
                CFG_FILL_BLUE:  fill_reg[2] <= cfg.data[FILL_W-1:0];
                CFG_OPACITY:    opac_reg    <= cfg.data[OPAC_W-1:0];
                CFG_BLEND_SEL:  sel_reg     <= cfg.data[SEL_W-1:0];
                CFG_DEEP_DEPTH: deep_reg    <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    // Values derived from configuration; the user keeps them static while pixels flow, the block does not enforce it
    logic [OPAC_W-1:0] op_sat;
    logic [OPA_W-1:0]  op_wide;
    fx_t               a_fx;
    fx_t               inv_a_fx;
    fx_t               c_fx [NCH];

    always_comb
    begin
        op_sat   = (opac_reg > OPAC_ONE) ? OPAC_ONE : opac_reg;
        op_wide  = (OPA_W'(op_sat) << FRAC_BITS) + (OPA_W'(1) << (OPAC_FRAC - 1));
        a_fx     = fx_t'(op_wide >> OPAC_FRAC);
        inv_a_fx = FX_ONE - a_fx;
        for (int i = 0; i < NCH; i++)
        begin
            c_fx[i] = FX_BYTE_LUT[fill_reg[i]];
        end
    end

    // Stage handshake: a stage loads when empty or when the next one moves
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   stg_rdy;
    logic [NSTG-1:0] stg_ld;

    always_comb
    begin
        stg_rdy[NSTG] = result.ready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            stg_rdy[k] = ~vld_reg[k] | stg_rdy[k+1];
        end
        stg_ld[0] = stg_rdy[0] & pixel.valid;
        for (int k = 1; k < NSTG; k++)
        begin
            stg_ld[k] = stg_rdy[k] & vld_reg[k-1];
        end
    end

    assign pixel.ready = stg_rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stg_rdy[0])
            begin
                vld_reg[0] <= pixel.valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (stg_rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Alpha travels alongside the color lanes
    pix_t alpha_reg [NSTG];

    always_ff @(posedge clk)
    begin
        if (stg_ld[0])
        begin
            alpha_reg[0] <= pixel.src_alpha;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (stg_ld[k])
            begin
                alpha_reg[k] <= alpha_reg[k-1];
            end
        end
    end

    // Stage 1: saturate and normalize source channels
    pix_t src_pix [NCH];
    fx_t  s0_fx   [NCH];
    fx_t  s1_reg  [NCH];

    always_comb
    begin
        pix_t             sat;
        logic [DW-1:0]    dwide;
        logic [FILL_W-1:0] sat8;
        src_pix[0] = pixel.src_red;
        src_pix[1] = pixel.src_green;
        src_pix[2] = pixel.src_blue;
        for (int i = 0; i < NCH; i++)
        begin
            sat   = (src_pix[i] > DEEP_SCALE) ? DEEP_SCALE : src_pix[i];
            dwide = ((DW'(sat) << FRAC_BITS) + (DW'(1) << (DEEP_LOG2 - 1))) >> DEEP_LOG2;
            sat8  = (src_pix[i] > BYTE_SCALE) ? '1 : src_pix[i][FILL_W-1:0];
            s0_fx[i] = deep_reg ? fx_t'(dwide) : FX_BYTE_LUT[sat8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ld[0])
        begin
            s1_reg <= s0_fx;
        end
    end

    // Stage 2: pick multiplier operands for the blend mode and multiply
    prod_t p2_reg [NCH];
    fx_t   s2_reg [NCH];
    prod_t p1_prod [NCH];

    always_comb
    begin
        fx_t op_p;
        fx_t op_q;
        for (int i = 0; i < NCH; i++)
        begin
            case (sel_reg)
                BLEND_MULTIPLY:
                begin
                    op_p = s1_reg[i];
                    op_q = c_fx[i];
                end
                BLEND_SCREEN:
                begin
                    op_p = FX_ONE - s1_reg[i];
                    op_q = FX_ONE - c_fx[i];
                end
                BLEND_OVERLAY:
                begin
                    if (s1_reg[i] < FX_HALF)
                    begin
                        op_p = s1_reg[i] << 1;
                        op_q = c_fx[i];
                    end
                    else
                    begin
                        op_p = (FX_ONE - s1_reg[i]) << 1;
                        op_q = FX_ONE - c_fx[i];
                    end
                end
                default:
                begin
                    op_p = '0;
                    op_q = '0;
                end
            endcase
            p1_prod[i] = PROD_W'(op_p) * PROD_W'(op_q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ld[1])
        begin
            p2_reg <= p1_prod;
            s2_reg <= s1_reg;
        end
    end

    // Stage 3: round the product and form the blend value
    fx_t b3_reg [NCH];
    fx_t s3_reg [NCH];
    fx_t b2_fx  [NCH];

    always_comb
    begin
        logic [TW-1:0]   t;
        logic [FX_W:0]   sum;
        for (int i = 0; i < NCH; i++)
        begin
            t   = TW'((p2_reg[i] + PROD_W'(FX_HALF)) >> FRAC_BITS);
            sum = {1'b0, s2_reg[i]} + {1'b0, c_fx[i]};
            case (sel_reg)
                BLEND_MULTIPLY: b2_fx[i] = fx_t'(t);
                BLEND_ADD:      b2_fx[i] = (sum > {1'b0, FX_ONE}) ? FX_ONE : sum[FX_W-1:0];
                BLEND_SCREEN:   b2_fx[i] = FX_ONE - fx_t'(t);
                BLEND_DIFF:
                begin
                    b2_fx[i] = (s2_reg[i] > c_fx[i]) ? (s2_reg[i] - c_fx[i])
                                                     : (c_fx[i] - s2_reg[i]);
                end
                BLEND_OVERLAY:
                begin
                    if (s2_reg[i] < FX_HALF)
                    begin
                        b2_fx[i] = (t < TW'(FX_ONE)) ? fx_t'(t) : FX_ONE;
                    end
                    else
                    begin
                        b2_fx[i] = (t < TW'(FX_ONE)) ? (FX_ONE - fx_t'(t)) : '0;
                    end
                end
                default:        b2_fx[i] = c_fx[i];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ld[2])
        begin
            b3_reg <= b2_fx;
            s3_reg <= s2_reg;
        end
    end

    // Stage 4: opacity weighting products
    prod_t ps4_reg [NCH];
    prod_t pb4_reg [NCH];

    always_ff @(posedge clk)
    begin
        if (stg_ld[3])
        begin
            for (int i = 0; i < NCH; i++)
            begin
                ps4_reg[i] <= PROD_W'(s3_reg[i]) * PROD_W'(inv_a_fx);
                pb4_reg[i] <= PROD_W'(b3_reg[i]) * PROD_W'(a_fx);
            end
        end
    end

    // Stage 5: sum, round and clamp the mix to one
    fx_t m5_reg [NCH];
    fx_t m4_fx  [NCH];

    always_comb
    begin
        logic [PROD_W:0] msum;
        logic [MW-1:0]   mq;
        for (int i = 0; i < NCH; i++)
        begin
            msum     = {1'b0, ps4_reg[i]} + {1'b0, pb4_reg[i]} + (PROD_W + 1)'(FX_HALF);
            mq       = MW'(msum >> FRAC_BITS);
            m4_fx[i] = (mq > MW'(FX_ONE)) ? FX_ONE : mq[FX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ld[4])
        begin
            m5_reg <= m4_fx;
        end
    end

    // Stage 6: rescale to the channel range with round half up
    pix_t out_reg [NCH];
    pix_t o5_pix  [NCH];

    always_comb
    begin
        logic [OW-1:0] scaled;
        for (int i = 0; i < NCH; i++)
        begin
            if (deep_reg)
            begin
                scaled = OW'(m5_reg[i]) << DEEP_LOG2;
            end
            else
            begin
                scaled = (OW'(m5_reg[i]) << FILL_W) - OW'(m5_reg[i]);
            end
            scaled    = scaled + OW'(FX_HALF);
            o5_pix[i] = pix_t'(scaled >> FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ld[5])
        begin
            out_reg <= o5_pix;
        end
    end

    // Result channel
    assign result.valid     = vld_reg[NSTG-1];
    assign result.out_alpha = alpha_reg[NSTG-1];
    assign result.out_red   = out_reg[0];
    assign result.out_green = out_reg[1];
    assign result.out_blue  = out_reg[2];

    // Checks
    `COB_ASSERT_NEXT(a_accept_lands, pixel.valid && pixel.ready, vld_reg[0],
        "accepted pixel did not enter the first stage")
    `COB_ASSERT_IMPL(a_blend_range, vld_reg[2],
        b3_reg[0] <= FX_ONE && b3_reg[1] <= FX_ONE && b3_reg[2] <= FX_ONE,
        "blend value above one")
    `COB_ASSERT_IMPL(a_byte_range, result.valid && !deep_reg,
        result.out_red <= BYTE_SCALE && result.out_green <= BYTE_SCALE &&
        result.out_blue <= BYTE_SCALE,
        "8-bit result above 255")

endmodule

`default_nettype wire
